### rtl/core/gatm_pkg.sv
// ----------------------------------------------------------------------------
// Glyph atlas text mapper package
// Shared types, constants and the fixed color table of the text mapper.
// ----------------------------------------------------------------------------
package gatm_pkg;

	localparam int CHAR_W     = 8;
	localparam int CELLS_W    = 9;
	localparam int INDEX_W    = 9;
	localparam int POS_W      = 16;
	localparam int COLOR_SEL_W = 3;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CHAR_W-1:0] ESCAPE_BYTE      = 8'd3;
	localparam int                COLOR_CODE_FIRST = 48;
	localparam int                COLOR_COUNT      = 8;
	localparam int                MAX_TEXTURES     = 256;
	localparam int                MAX_CELLS        = 256;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHAR     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CHAR      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_PER_SIDE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_COUNT  = 2'd3;

	localparam logic [CHAR_W-1:0]  FIRST_CHAR_RST     = 8'd32;
	localparam logic [CHAR_W-1:0]  LAST_CHAR_RST      = 8'd127;
	localparam logic [CELLS_W-1:0] CELLS_PER_SIDE_RST = 9'd16;
	localparam logic [CELLS_W-1:0] TEXTURE_COUNT_RST  = 9'd1;

	localparam logic [23:0] COLOR_TABLE [COLOR_COUNT] = '{
		24'hFFFFFF, 24'h000000, 24'hFF0000, 24'hFF8000,
		24'hFFFF00, 24'h80FF00, 24'h00FF00, 24'h00FF80
	};

	typedef enum logic [1:0] {
		ENT_END,
		ENT_COLOR,
		ENT_GLYPH
	} gatm_kind_t;

	typedef struct packed {
		gatm_kind_t             kind;
		logic [COLOR_SEL_W-1:0] color_sel;
		logic [INDEX_W-1:0]     index;
		logic [POS_W-1:0]       position;
		logic                   last;
	} gatm_entry_t;

	typedef struct packed {
		logic             result_kind;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [7:0]       texture;
		logic             new_texture;
		logic [7:0]       cell_col;
		logic [7:0]       cell_row;
		logic [POS_W-1:0] position;
	} gatm_result_t;

endpackage

### rtl/core/glyph_atlas_text_mapper.sv
// ----------------------------------------------------------------------------
// Glyph atlas text mapper
// Maps string bytes to glyph atlas cells and color escapes to colors.
// ----------------------------------------------------------------------------
// The front end takes one byte per cycle while its four-entry queue has room.
// A glyph byte goes through load, two 9-step passes of a bit-serial
// divider (index by cells per side, then the quotient again), range
// check and result stages; a color escape goes from load to result.
// Other bytes use no back-end time unless they end a string. The result
// register lets the back end start the next byte while a result waits.
module glyph_atlas_text_mapper import gatm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // char_byte
	input  logic                 s_tlast,  // string_end
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// red, green, blue, texture, new_texture, cell_col, cell_row, position
	output logic [71:0]          m_tdata,
	output logic                 m_tuser,  // result_kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CELLS_W-1:0]   cfg_data
);

	logic [CHAR_W-1:0]  first_char_q;
	logic [CHAR_W-1:0]  last_char_q;
	logic [CELLS_W-1:0] cells_per_side_q;
	logic [CELLS_W-1:0] texture_count_q;

	logic         q_full;
	logic         q_push;
	gatm_entry_t  q_in;
	logic         q_pop;
	logic         q_not_empty;
	gatm_entry_t  q_out;
	gatm_result_t result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_char_q     <= FIRST_CHAR_RST;
			last_char_q      <= LAST_CHAR_RST;
			cells_per_side_q <= CELLS_PER_SIDE_RST;
			texture_count_q  <= TEXTURE_COUNT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FIRST_CHAR:     first_char_q     <= cfg_data[CHAR_W-1:0];
				REG_LAST_CHAR:      last_char_q      <= cfg_data[CHAR_W-1:0];
				REG_CELLS_PER_SIDE: cells_per_side_q <= cfg_data;
				REG_TEXTURE_COUNT:  texture_count_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	gatm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_byte  (s_tdata),
		.string_end (s_tlast),
		.first_char (first_char_q),
		.last_char  (last_char_q),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_entry    (q_in)
	);

	gatm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.pop_entry  (q_out)
	);

	gatm_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.entry_valid    (q_not_empty),
		.entry          (q_out),
		.entry_pop      (q_pop),
		.cells_per_side (cells_per_side_q),
		.texture_count  (texture_count_q),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_result     (result)
	);

	assign m_tuser = result.result_kind;
	assign m_tdata = {7'd0, result.position, result.cell_row, result.cell_col,
		result.new_texture, result.texture, result.blue, result.green, result.red};

endmodule

### rtl/core/gatm_front.sv
// ----------------------------------------------------------------------------
// Glyph atlas text mapper front end
// Accepts string bytes, tracks escapes and byte positions, and queues work.
// ----------------------------------------------------------------------------
module gatm_front import gatm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CHAR_W-1:0] char_byte,
	input  logic              string_end,
	input  logic [CHAR_W-1:0] first_char,
	input  logic [CHAR_W-1:0] last_char,
	input  logic              q_full,
	output logic              q_push,
	output gatm_entry_t       q_entry
);

	logic             escape_q;
	logic [POS_W-1:0] pos_q;
	logic             accept;
	logic             is_color;
	logic             in_range;

	assign in_ready = !q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		is_color = ({1'b0, char_byte} >= 9'(COLOR_CODE_FIRST)) &&
			({1'b0, char_byte} < 9'(COLOR_CODE_FIRST + COLOR_COUNT));
		in_range = (char_byte >= first_char) && (char_byte <= last_char);
		q_entry.color_sel = COLOR_SEL_W'(char_byte - CHAR_W'(COLOR_CODE_FIRST));
		q_entry.index     = {1'b0, char_byte} - {1'b0, first_char} + INDEX_W'(1);
		q_entry.position  = pos_q;
		q_entry.last      = string_end;
		q_entry.kind      = ENT_END;
		if (escape_q) begin
			if (is_color) begin
				q_entry.kind = ENT_COLOR;
			end
		end else if (char_byte != ESCAPE_BYTE && in_range) begin
			q_entry.kind = ENT_GLYPH;
		end
		q_push = accept && (q_entry.kind != ENT_END || string_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_q <= 1'b0;
			pos_q    <= '0;
		end else if (accept) begin
			if (string_end) begin
				escape_q <= 1'b0;
				pos_q    <= '0;
			end else begin
				escape_q <= !escape_q && (char_byte == ESCAPE_BYTE);
				if (pos_q != '1) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

endmodule

### rtl/core/gatm_queue.sv
// ----------------------------------------------------------------------------
// Glyph atlas text mapper work queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module gatm_queue import gatm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  gatm_entry_t push_entry,
	output logic        full,
	input  logic        pop,
	output logic        not_empty,
	output gatm_entry_t pop_entry
);

	localparam int DEPTH   = 4;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int COUNT_W = $clog2(DEPTH + 1);

	gatm_entry_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [COUNT_W-1:0] count_q;

	assign full      = (count_q == COUNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_entry = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

endmodule

### rtl/core/gatm_back.sv
// ----------------------------------------------------------------------------
// Glyph atlas text mapper back end
// Splits glyph indexes into texture and cell with a serial divider and
// drives the registered result.
// ----------------------------------------------------------------------------
module gatm_back import gatm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               entry_valid,
	input  gatm_entry_t        entry,
	output logic               entry_pop,
	input  logic [CELLS_W-1:0] cells_per_side,
	input  logic [CELLS_W-1:0] texture_count,
	output logic               out_valid,
	input  logic               out_ready,
	output gatm_result_t       out_result
);

	localparam int DIV_STEPS = INDEX_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_COL,
		ST_DIV_ROW,
		ST_CHECK,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	gatm_kind_t             kind_q;
	logic [COLOR_SEL_W-1:0] sel_q;
	logic [POS_W-1:0]       pos_q;
	logic                   last_q;
	logic [INDEX_W-1:0]     quo_q;
	logic [CELLS_W-1:0]     rem_q;
	logic [STEP_W-1:0]      step_q;
	logic [7:0]             col_q;
	logic                   bound_valid_q;
	logic [7:0]             bound_tex_q;
	logic                   out_valid_q;
	gatm_result_t           out_q;

	logic [CELLS_W-1:0]     cells_eff;
	logic [CELLS_W-1:0]     count_eff;
	logic [CELLS_W+1:0]     diff;
	logic [CELLS_W-1:0]     rem_nx;
	logic [INDEX_W-1:0]     quo_nx;
	logic [23:0]            color;
	gatm_result_t           res_nx;
	logic                   emit;

	assign entry_pop  = (state_q == ST_IDLE) && entry_valid;
	assign out_valid  = out_valid_q;
	assign out_result = out_q;
	assign color      = COLOR_TABLE[sel_q];
	assign emit       = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		if (cells_per_side == '0) begin
			cells_eff = CELLS_W'(1);
		end else if (cells_per_side > CELLS_W'(MAX_CELLS)) begin
			cells_eff = CELLS_W'(MAX_CELLS);
		end else begin
			cells_eff = cells_per_side;
		end
		if (texture_count > CELLS_W'(MAX_TEXTURES)) begin
			count_eff = CELLS_W'(MAX_TEXTURES);
		end else begin
			count_eff = texture_count;
		end
		diff = {1'b0, rem_q, quo_q[INDEX_W-1]} - {2'b00, cells_eff};
		if (diff[CELLS_W+1]) begin
			rem_nx = {rem_q[CELLS_W-2:0], quo_q[INDEX_W-1]};
			quo_nx = {quo_q[INDEX_W-2:0], 1'b0};
		end else begin
			rem_nx = diff[CELLS_W-1:0];
			quo_nx = {quo_q[INDEX_W-2:0], 1'b1};
		end
		res_nx = '0;
		if (kind_q == ENT_GLYPH) begin
			res_nx.result_kind = 1'b1;
			res_nx.texture     = quo_q[7:0];
			res_nx.new_texture = !bound_valid_q || (bound_tex_q != quo_q[7:0]);
			res_nx.cell_col    = col_q;
			res_nx.cell_row    = rem_q[7:0];
			res_nx.position    = pos_q;
		end else begin
			res_nx.red   = color[23:16];
			res_nx.green = color[15:8];
			res_nx.blue  = color[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kind_q        <= ENT_END;
			sel_q         <= '0;
			pos_q         <= '0;
			last_q        <= 1'b0;
			quo_q         <= '0;
			rem_q         <= '0;
			step_q        <= '0;
			col_q         <= '0;
			bound_valid_q <= 1'b0;
			bound_tex_q   <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (entry_valid) begin
						kind_q <= entry.kind;
						sel_q  <= entry.color_sel;
						pos_q  <= entry.position;
						last_q <= entry.last;
						quo_q  <= entry.index;
						rem_q  <= '0;
						step_q <= STEP_W'(DIV_STEPS - 1);
						case (entry.kind)
							ENT_GLYPH: state_q <= ST_DIV_COL;
							ENT_COLOR: state_q <= ST_EMIT;
							default: begin
								if (entry.last) begin
									bound_valid_q <= 1'b0;
									bound_tex_q   <= '0;
								end
							end
						endcase
					end
				end
				ST_DIV_COL: begin
					quo_q <= quo_nx;
					if (step_q == '0) begin
						col_q   <= rem_nx[7:0];
						rem_q   <= '0;
						step_q  <= STEP_W'(DIV_STEPS - 1);
						state_q <= ST_DIV_ROW;
					end else begin
						rem_q  <= rem_nx;
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_DIV_ROW: begin
					quo_q <= quo_nx;
					rem_q <= rem_nx;
					if (step_q == '0) begin
						state_q <= ST_CHECK;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_CHECK: begin
					if (quo_q < count_eff) begin
						state_q <= ST_EMIT;
					end else begin
						if (last_q) begin
							bound_valid_q <= 1'b0;
							bound_tex_q   <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit) begin
						out_q <= res_nx;
						if (last_q) begin
							bound_valid_q <= 1'b0;
							bound_tex_q   <= '0;
						end else if (kind_q == ENT_GLYPH) begin
							bound_valid_q <= 1'b1;
							bound_tex_q   <= quo_q[7:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
